[src/hpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpe_pkg
// Shared types, constants and helpers of the Hermite profile evaluator.
// ----------------------------------------------------------------------------
package hpe_pkg;

    // Knot store geometry
    localparam int MAX_KNOTS = 64;
    localparam int IDX_W     = $clog2(MAX_KNOTS);
    localparam int CNT_W     = $clog2(MAX_KNOTS + 1);
    localparam int ADDR_W    = $clog2(2 * MAX_KNOTS);

    // Fixed widths of the datapath
    localparam int KNOT_W    = 96;     // {gradient, level, station}
    localparam int Q_W       = 52;     // quotients clamped to 2^50
    localparam int HM_W      = 49;     // h * m rounded to Q16.16
    localparam int DIV_STEPS = 68;     // dividend bits of the restoring divider
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Operation codes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Status codes
    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_NO_LINE  = 3'd1,
        STS_TOO_MANY = 3'd2,
        STS_OUTSIDE  = 3'd3,
        STS_NOT_INC  = 3'd4
    } t_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LINE_LAID = 2'd0,
        CFG_LINE_LEN  = 2'd1,
        CFG_STN_TOL   = 2'd2
    } t_cfg_idx;

    // Main sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_CHK,
        S_Q_START,
        S_Q_FIRST,
        S_Q_LAST,
        S_EXT_ISSUE,
        S_EXT_WAIT,
        S_SRCH,
        S_SRCH_CMP,
        S_RD_A,
        S_RD_B,
        S_RUN_ISSUE,
        S_RUN_WAIT,
        S_OUT
    } t_state;

    // Steps of the interior evaluation program
    typedef enum logic [4:0] {
        STP_T, STP_TT, STP_TTT, STP_HM0, STP_HM1,
        STP_V0, STP_V1, STP_V2, STP_V3,
        STP_S, STP_R0, STP_R1, STP_R2,
        STP_S2, STP_P0, STP_P1,
        STP_B0, STP_B1, STP_B2
    } t_step;

    // Multiply/divide unit states
    typedef enum logic [2:0] {
        MDU_IDLE,
        MDU_MUL_LO,
        MDU_MUL_HI,
        MDU_MUL_SUM,
        MDU_MUL_FIN,
        MDU_DIV,
        MDU_DIV_FIN
    } t_mdu_state;

    // Request to the multiply/divide unit
    typedef struct packed {
        logic               start;
        logic               is_div;
        logic               shift16;  // Q16 scaling instead of Q32
        logic               rnd;      // round to nearest on multiply
        logic signed [63:0] opa;
        logic signed [33:0] opb;
        logic [31:0]        den;
    } t_mdu_req;

    localparam logic signed [35:0] Q32_ONE = 36'sh1_0000_0000;

    // Clamp a Q0.32 weight to [-1, 1]
    function automatic logic signed [33:0] clamp_one(input logic signed [35:0] v);
        logic signed [35:0] c;
        begin
            c = v;
            if (v > Q32_ONE) begin
                c = Q32_ONE;
            end else if (v < -Q32_ONE) begin
                c = -Q32_ONE;
            end
            clamp_one = c[33:0];
        end
    endfunction

    // Saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            r = v[31:0];
            if (v > 64'sh0000_0000_7FFF_FFFF) begin
                r = 32'sh7FFF_FFFF;
            end else if (v < -64'sh0000_0000_8000_0000) begin
                r = 32'sh8000_0000;
            end
            sat32 = r;
        end
    endfunction

endpackage

[src/hpe_mdu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpe_mdu
// Shared multiply/divide unit: sign-magnitude multiply in two 32x33 partial
// products with rounding and Q16/Q32 scaling, and a restoring divider that
// retires one quotient bit per cycle with the quotient clamped to 2^50.
// ----------------------------------------------------------------------------
module hpe_mdu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hpe_pkg::t_mdu_req  i_req,
    output logic               o_done,
    output logic signed [63:0] o_result
);

    hpe_pkg::t_mdu_state r_state, n_state;

    logic [63:0]                 r_ua;
    logic [32:0]                 r_ub;
    logic                        r_neg;
    logic                        r_shift16;
    logic                        r_rnd;
    logic [31:0]                 r_den;
    logic [64:0]                 r_pp;
    logic [96:0]                 r_sum;
    logic [67:0]                 r_dq;
    logic [31:0]                 r_rem;
    logic [hpe_pkg::DCNT_W-1:0]  r_cnt;
    logic                        r_done;
    logic signed [63:0]          r_res;

    logic [63:0]  req_ua;
    logic [33:0]  req_ub;
    logic [32:0]  div_t;
    logic         div_ge;
    logic [96:0]  mul_rnd;
    logic [96:0]  mul_sh;
    logic [63:0]  quo_mag;

    // Operand magnitudes
    assign req_ua = i_req.opa[63] ? 64'(-i_req.opa) : 64'(i_req.opa);
    assign req_ub = i_req.opb[33] ? 34'(-i_req.opb) : 34'(i_req.opb);

    // Divider step
    assign div_t  = {r_rem, r_dq[67]};
    assign div_ge = div_t >= {1'b0, r_den};

    // Rounding, scaling and clamping of results
    always_comb begin
        mul_rnd = r_sum;
        if (r_rnd) begin
            mul_rnd = r_sum + (r_shift16 ? 97'h8000 : 97'h8000_0000);
        end
        mul_sh  = r_shift16 ? (mul_rnd >> 16) : (mul_rnd >> 32);
        quo_mag = (|r_dq[67:50]) ? (64'd1 << 50) : {14'd0, r_dq[49:0]};
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hpe_pkg::MDU_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == hpe_pkg::MDU_MUL_FIN) || (r_state == hpe_pkg::MDU_DIV_FIN);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hpe_pkg::MDU_IDLE: begin
                if (i_req.start) begin
                    n_state = i_req.is_div ? hpe_pkg::MDU_DIV : hpe_pkg::MDU_MUL_LO;
                end
            end
            hpe_pkg::MDU_MUL_LO:  n_state = hpe_pkg::MDU_MUL_HI;
            hpe_pkg::MDU_MUL_HI:  n_state = hpe_pkg::MDU_MUL_SUM;
            hpe_pkg::MDU_MUL_SUM: n_state = hpe_pkg::MDU_MUL_FIN;
            hpe_pkg::MDU_MUL_FIN: n_state = hpe_pkg::MDU_IDLE;
            hpe_pkg::MDU_DIV: begin
                if (r_cnt == hpe_pkg::DCNT_W'(hpe_pkg::DIV_STEPS - 1)) begin
                    n_state = hpe_pkg::MDU_DIV_FIN;
                end
            end
            hpe_pkg::MDU_DIV_FIN: n_state = hpe_pkg::MDU_IDLE;
            default:              n_state = hpe_pkg::MDU_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            hpe_pkg::MDU_IDLE: begin
                if (i_req.start) begin
                    r_ua      <= req_ua;
                    r_ub      <= req_ub[32:0];
                    r_shift16 <= i_req.shift16;
                    r_rnd     <= i_req.rnd;
                    r_den     <= i_req.den;
                    r_neg     <= i_req.is_div ? i_req.opa[63] : (i_req.opa[63] ^ i_req.opb[33]);
                    r_dq      <= i_req.shift16 ? (68'(req_ua) << 16) : (68'(req_ua) << 32);
                    r_rem     <= '0;
                    r_cnt     <= '0;
                end
            end
            hpe_pkg::MDU_MUL_LO: begin
                r_pp <= r_ua[31:0] * r_ub;
            end
            hpe_pkg::MDU_MUL_HI: begin
                r_pp  <= r_ua[63:32] * r_ub;
                r_sum <= 97'(r_pp);
            end
            hpe_pkg::MDU_MUL_SUM: begin
                r_sum <= r_sum + (97'(r_pp) << 32);
            end
            hpe_pkg::MDU_MUL_FIN: begin
                r_res <= r_neg ? -$signed(mul_sh[63:0]) : $signed(mul_sh[63:0]);
            end
            hpe_pkg::MDU_DIV: begin
                r_rem <= div_ge ? 32'(div_t - {1'b0, r_den}) : div_t[31:0];
                r_dq  <= {r_dq[66:0], div_ge};
                r_cnt <= r_cnt + hpe_pkg::DCNT_W'(1);
            end
            hpe_pkg::MDU_DIV_FIN: begin
                r_res <= r_neg ? -$signed(quo_mag) : $signed(quo_mag);
            end
            default: begin
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

[src/hermite_profile_evaluator_core.sv]
`timescale 1ns / 1ps
// Clear and unused operations go straight to the output; a knot load reads
// the last knot and checks it; an extrapolated query takes one multiply and
// an interior query a binary search, then 5 divisions and 14 multiplies
// on the shared multiply/divide unit.
// One item at a time; the next beat is taken once the result is in the output
// register. Synchronous active-low reset empties both profiles.
// ----------------------------------------------------------------------------
// hermite_profile_evaluator_core
// Holds height and bank knot tables in one knot memory, checks knot loads and
// evaluates cubic Hermite value, rate and bend with linear extrapolation.
// ----------------------------------------------------------------------------
module hermite_profile_evaluator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // station[31:0], level[63:32], gradient[95:64]
    input  logic [3:0]  s_axis_tuser,   // operation[1:0], profile[2], first_knot[3]
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // out_value[31:0], out_rate[63:32], out_bend[95:64]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    // Configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W  = hpe_pkg::IDX_W;
    localparam int CNT_W  = hpe_pkg::CNT_W;
    localparam int ADDR_W = hpe_pkg::ADDR_W;

    hpe_pkg::t_state r_state, n_state;
    hpe_pkg::t_step  r_step;

    // Configuration registers
    logic        r_laid;
    logic [31:0] r_len;
    logic [15:0] r_tol;

    // Profile control
    logic [CNT_W-1:0] r_count [2];
    logic             r_aband [2];

    // Knot memory
    logic [hpe_pkg::KNOT_W-1:0] r_mem [2 * hpe_pkg::MAX_KNOTS];
    logic [hpe_pkg::KNOT_W-1:0] r_rdata;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]          wr_addr;
    logic                       mem_we;

    // Item registers
    logic               r_prof;
    logic [31:0]        r_x;
    logic signed [31:0] r_lvl;
    logic signed [31:0] r_grad;

    // Knot pair and search bounds
    logic [31:0]        r_s0, r_s1;
    logic signed [31:0] r_y0, r_y1, r_m0, r_m1;
    logic [IDX_W-1:0]   r_lo, r_hi;
    logic               r_ext_b;

    // Evaluation registers
    logic [31:0]                   r_t, r_tt, r_ttt;
    logic signed [hpe_pkg::HM_W-1:0] r_hm0, r_hm1;
    logic signed [hpe_pkg::Q_W-1:0]  r_s, r_s2, r_p0, r_p1;
    logic signed [63:0]            r_acc;

    // Result and output registers
    hpe_pkg::t_status   r_rs_status;
    logic signed [31:0] r_rs_val, r_rs_rate, r_rs_bend;
    logic               r_out_valid;
    logic [2:0]         r_out_status;
    logic [95:0]        r_out_data;

    // Multiply/divide unit
    hpe_pkg::t_mdu_req  mdu_req;
    logic               mdu_done;
    logic signed [63:0] mdu_res;

    // Misc combinational
    logic               accept;
    logic [CNT_W-1:0]   cur_cnt, cnt_m1;
    logic [IDX_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid;
    logic [32:0]        stn_limit;
    logic [31:0]        rd_st;
    logic [31:0]        h, u;
    logic signed [35:0] t36, tt36, ttt36;
    logic signed [33:0] w00, w01, w10, w11, wr0, wr1;
    logic signed [63:0] six_r;
    hpe_pkg::t_status   ld_code;
    logic               out_free;

    function automatic logic [ADDR_W-1:0] knot_addr(input logic p, input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        begin
            base      = p ? ADDR_W'(hpe_pkg::MAX_KNOTS) : '0;
            knot_addr = base + ADDR_W'(idx);
        end
    endfunction

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign cur_cnt  = r_count[r_prof];
    assign cnt_m1   = cur_cnt - CNT_W'(1);
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi} + (IDX_W + 1)'(1);
    assign mid      = mid_sum[IDX_W:1];
    assign rd_st    = r_rdata[31:0];
    assign stn_limit = {1'b0, r_len} + 33'(r_tol);
    assign h        = r_s1 - r_s0;
    assign u        = r_x - r_s0;

    // Hermite weights in Q0.32
    assign t36   = 36'(r_t);
    assign tt36  = 36'(r_tt);
    assign ttt36 = 36'(r_ttt);
    assign w00 = hpe_pkg::clamp_one(2 * ttt36 - 3 * tt36 + hpe_pkg::Q32_ONE);
    assign w01 = hpe_pkg::clamp_one(3 * tt36 - 2 * ttt36);
    assign w10 = hpe_pkg::clamp_one(ttt36 - 2 * tt36 + t36);
    assign w11 = hpe_pkg::clamp_one(ttt36 - tt36);
    assign wr0 = hpe_pkg::clamp_one(3 * tt36 - 4 * t36 + hpe_pkg::Q32_ONE);
    assign wr1 = hpe_pkg::clamp_one(3 * tt36 - 2 * t36);
    assign six_r = (mdu_res <<< 2) + (mdu_res <<< 1);

    // Knot check, in priority order
    always_comb begin
        ld_code = hpe_pkg::STS_OK;
        if (!r_laid) begin
            ld_code = hpe_pkg::STS_NO_LINE;
        end else if (cur_cnt >= CNT_W'(hpe_pkg::MAX_KNOTS)) begin
            ld_code = hpe_pkg::STS_TOO_MANY;
        end else if ({1'b0, r_x} > stn_limit) begin
            ld_code = hpe_pkg::STS_OUTSIDE;
        end else if ((cur_cnt != '0) && (r_x <= rd_st)) begin
            ld_code = hpe_pkg::STS_NOT_INC;
        end
    end

    // Next state, memory addresses and unit requests
    always_comb begin
        n_state        = r_state;
        rd_addr        = knot_addr(r_prof, cnt_m1[IDX_W-1:0]);
        wr_addr        = knot_addr(r_prof, cur_cnt[IDX_W-1:0]);
        mem_we         = 1'b0;
        mdu_req        = '0;
        mdu_req.den    = h;
        mdu_req.rnd    = 1'b1;
        case (r_state)
            hpe_pkg::S_IDLE: begin
                if (accept) begin
                    case (hpe_pkg::t_op'(s_axis_tuser[1:0]))
                        hpe_pkg::OP_LOAD:  n_state = hpe_pkg::S_LD_RD;
                        hpe_pkg::OP_QUERY: n_state = hpe_pkg::S_Q_START;
                        default:           n_state = hpe_pkg::S_OUT;
                    endcase
                end
            end
            hpe_pkg::S_LD_RD:  n_state = hpe_pkg::S_LD_CHK;
            hpe_pkg::S_LD_CHK: begin
                mem_we  = !r_aband[r_prof] && (ld_code == hpe_pkg::STS_OK);
                n_state = hpe_pkg::S_OUT;
            end
            hpe_pkg::S_Q_START: begin
                rd_addr = knot_addr(r_prof, '0);
                n_state = (cur_cnt == '0) ? hpe_pkg::S_OUT : hpe_pkg::S_Q_FIRST;
            end
            hpe_pkg::S_Q_FIRST: n_state = hpe_pkg::S_Q_LAST;
            hpe_pkg::S_Q_LAST: begin
                if ((r_x <= r_s0) || (r_x >= rd_st)) begin
                    n_state = hpe_pkg::S_EXT_ISSUE;
                end else begin
                    n_state = hpe_pkg::S_SRCH;
                end
            end
            hpe_pkg::S_EXT_ISSUE: begin
                mdu_req.start   = 1'b1;
                mdu_req.shift16 = 1'b1;
                mdu_req.opa     = 64'($signed({1'b0, r_x}) -
                                      $signed({1'b0, (r_ext_b ? r_s1 : r_s0)}));
                mdu_req.opb     = 34'(r_ext_b ? r_m1 : r_m0);
                n_state         = hpe_pkg::S_EXT_WAIT;
            end
            hpe_pkg::S_EXT_WAIT: begin
                if (mdu_done) begin
                    n_state = hpe_pkg::S_OUT;
                end
            end
            hpe_pkg::S_SRCH: begin
                if (r_lo < r_hi) begin
                    rd_addr = knot_addr(r_prof, mid);
                    n_state = hpe_pkg::S_SRCH_CMP;
                end else begin
                    rd_addr = knot_addr(r_prof, r_lo);
                    n_state = hpe_pkg::S_RD_A;
                end
            end
            hpe_pkg::S_SRCH_CMP: n_state = hpe_pkg::S_SRCH;
            hpe_pkg::S_RD_A: begin
                rd_addr = knot_addr(r_prof, r_lo + IDX_W'(1));
                n_state = hpe_pkg::S_RD_B;
            end
            hpe_pkg::S_RD_B: n_state = hpe_pkg::S_RUN_ISSUE;
            hpe_pkg::S_RUN_ISSUE: begin
                mdu_req.start = 1'b1;
                case (r_step)
                    hpe_pkg::STP_T: begin
                        mdu_req.is_div = 1'b1;
                        mdu_req.opa    = 64'(u);
                    end
                    hpe_pkg::STP_TT: begin
                        mdu_req.rnd = 1'b0;
                        mdu_req.opa = 64'(r_t);
                        mdu_req.opb = 34'(r_t);
                    end
                    hpe_pkg::STP_TTT: begin
                        mdu_req.rnd = 1'b0;
                        mdu_req.opa = 64'(r_tt);
                        mdu_req.opb = 34'(r_t);
                    end
                    hpe_pkg::STP_HM0: begin
                        mdu_req.shift16 = 1'b1;
                        mdu_req.opa     = 64'(h);
                        mdu_req.opb     = 34'(r_m0);
                    end
                    hpe_pkg::STP_HM1: begin
                        mdu_req.shift16 = 1'b1;
                        mdu_req.opa     = 64'(h);
                        mdu_req.opb     = 34'(r_m1);
                    end
                    hpe_pkg::STP_V0: begin
                        mdu_req.opa = 64'(r_y0);
                        mdu_req.opb = w00;
                    end
                    hpe_pkg::STP_V1: begin
                        mdu_req.opa = 64'(r_y1);
                        mdu_req.opb = w01;
                    end
                    hpe_pkg::STP_V2: begin
                        mdu_req.opa = 64'(r_hm0);
                        mdu_req.opb = w10;
                    end
                    hpe_pkg::STP_V3: begin
                        mdu_req.opa = 64'(r_hm1);
                        mdu_req.opb = w11;
                    end
                    hpe_pkg::STP_S: begin
                        mdu_req.is_div  = 1'b1;
                        mdu_req.shift16 = 1'b1;
                        mdu_req.opa     = 64'(r_y1) - 64'(r_y0);
                    end
                    hpe_pkg::STP_R0: begin
                        mdu_req.opa = 64'(r_s);
                        mdu_req.opb = 34'(r_t) - 34'(r_tt);
                    end
                    hpe_pkg::STP_R1: begin
                        mdu_req.opa = 64'(r_m0);
                        mdu_req.opb = wr0;
                    end
                    hpe_pkg::STP_R2: begin
                        mdu_req.opa = 64'(r_m1);
                        mdu_req.opb = wr1;
                    end
                    hpe_pkg::STP_S2: begin
                        mdu_req.is_div  = 1'b1;
                        mdu_req.shift16 = 1'b1;
                        mdu_req.opa     = 64'(r_s);
                    end
                    hpe_pkg::STP_P0: begin
                        mdu_req.is_div  = 1'b1;
                        mdu_req.shift16 = 1'b1;
                        mdu_req.opa     = 64'(r_m0);
                    end
                    hpe_pkg::STP_P1: begin
                        mdu_req.is_div  = 1'b1;
                        mdu_req.shift16 = 1'b1;
                        mdu_req.opa     = 64'(r_m1);
                    end
                    hpe_pkg::STP_B0: begin
                        mdu_req.opa = 64'(r_s2);
                        mdu_req.opb = 34'(hpe_pkg::Q32_ONE - 2 * t36);
                    end
                    hpe_pkg::STP_B1: begin
                        mdu_req.opa = 64'(r_p0);
                        mdu_req.opb = 34'(r_t);
                    end
                    hpe_pkg::STP_B2: begin
                        mdu_req.opa = 64'(r_p1);
                        mdu_req.opb = 34'(r_t);
                    end
                    default: begin
                        mdu_req.start = 1'b0;
                    end
                endcase
                n_state = hpe_pkg::S_RUN_WAIT;
            end
            hpe_pkg::S_RUN_WAIT: begin
                if (mdu_done) begin
                    n_state = (r_step == hpe_pkg::STP_B2) ? hpe_pkg::S_OUT
                                                          : hpe_pkg::S_RUN_ISSUE;
                end
            end
            hpe_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = hpe_pkg::S_IDLE;
                end
            end
            default: n_state = hpe_pkg::S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == hpe_pkg::S_IDLE);

    // Knot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= {r_grad, r_lvl, r_x};
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpe_pkg::S_IDLE;
            r_laid      <= 1'b0;
            r_len       <= '0;
            r_tol       <= 16'd66;
            r_count[0]  <= '0;
            r_count[1]  <= '0;
            r_aband[0]  <= 1'b0;
            r_aband[1]  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Configuration; a new line empties both profiles
            if (i_cfg_we) begin
                case (hpe_pkg::t_cfg_idx'(i_cfg_index))
                    hpe_pkg::CFG_LINE_LAID: begin
                        r_laid     <= i_cfg_data[0];
                        r_count[0] <= '0;
                        r_count[1] <= '0;
                        r_aband[0] <= 1'b0;
                        r_aband[1] <= 1'b0;
                    end
                    hpe_pkg::CFG_LINE_LEN: begin
                        r_len      <= i_cfg_data;
                        r_count[0] <= '0;
                        r_count[1] <= '0;
                        r_aband[0] <= 1'b0;
                        r_aband[1] <= 1'b0;
                    end
                    hpe_pkg::CFG_STN_TOL: begin
                        r_tol <= i_cfg_data[15:0];
                    end
                    default: begin
                    end
                endcase
            end

            // First knot of a load or a clear empties the profile
            if (accept) begin
                case (hpe_pkg::t_op'(s_axis_tuser[1:0]))
                    hpe_pkg::OP_LOAD: begin
                        if (s_axis_tuser[3]) begin
                            r_count[s_axis_tuser[2]] <= '0;
                            r_aband[s_axis_tuser[2]] <= 1'b0;
                        end
                    end
                    hpe_pkg::OP_CLEAR: begin
                        r_count[s_axis_tuser[2]] <= '0;
                        r_aband[s_axis_tuser[2]] <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            // Knot check outcome
            if ((r_state == hpe_pkg::S_LD_CHK) && !r_aband[r_prof]) begin
                if (ld_code == hpe_pkg::STS_OK) begin
                    r_count[r_prof] <= cur_cnt + CNT_W'(1);
                end else begin
                    r_count[r_prof] <= '0;
                    r_aband[r_prof] <= 1'b1;
                end
            end

            // Output register
            if ((r_state == hpe_pkg::S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            hpe_pkg::S_IDLE: begin
                if (accept) begin
                    r_prof      <= s_axis_tuser[2];
                    r_x         <= s_axis_tdata[31:0];
                    r_lvl       <= s_axis_tdata[63:32];
                    r_grad      <= s_axis_tdata[95:64];
                    r_rs_status <= hpe_pkg::STS_OK;
                    r_rs_val    <= '0;
                    r_rs_rate   <= '0;
                    r_rs_bend   <= '0;
                end
            end
            hpe_pkg::S_LD_CHK: begin
                if (!r_aband[r_prof]) begin
                    r_rs_status <= ld_code;
                end
            end
            hpe_pkg::S_Q_FIRST: begin
                r_s0 <= r_rdata[31:0];
                r_y0 <= r_rdata[63:32];
                r_m0 <= r_rdata[95:64];
            end
            hpe_pkg::S_Q_LAST: begin
                r_s1    <= r_rdata[31:0];
                r_y1    <= r_rdata[63:32];
                r_m1    <= r_rdata[95:64];
                r_ext_b <= !(r_x <= r_s0);
                r_lo    <= '0;
                r_hi    <= cnt_m1[IDX_W-1:0];
            end
            hpe_pkg::S_EXT_WAIT: begin
                if (mdu_done) begin
                    r_rs_val  <= hpe_pkg::sat32(64'(r_ext_b ? r_y1 : r_y0) + mdu_res);
                    r_rs_rate <= r_ext_b ? r_m1 : r_m0;
                end
            end
            hpe_pkg::S_SRCH_CMP: begin
                if (rd_st <= r_x) begin
                    r_lo <= mid;
                end else begin
                    r_hi <= mid - IDX_W'(1);
                end
            end
            hpe_pkg::S_RD_A: begin
                r_s0 <= r_rdata[31:0];
                r_y0 <= r_rdata[63:32];
                r_m0 <= r_rdata[95:64];
            end
            hpe_pkg::S_RD_B: begin
                r_s1   <= r_rdata[31:0];
                r_y1   <= r_rdata[63:32];
                r_m1   <= r_rdata[95:64];
                r_step <= hpe_pkg::STP_T;
            end
            hpe_pkg::S_RUN_WAIT: begin
                if (mdu_done) begin
                    r_step <= hpe_pkg::t_step'(r_step + 5'd1);
                    case (r_step)
                        hpe_pkg::STP_T:   r_t   <= mdu_res[31:0];
                        hpe_pkg::STP_TT:  r_tt  <= mdu_res[31:0];
                        hpe_pkg::STP_TTT: r_ttt <= mdu_res[31:0];
                        hpe_pkg::STP_HM0: r_hm0 <= hpe_pkg::HM_W'(mdu_res);
                        hpe_pkg::STP_HM1: r_hm1 <= hpe_pkg::HM_W'(mdu_res);
                        hpe_pkg::STP_V0:  r_acc <= mdu_res;
                        hpe_pkg::STP_V1:  r_acc <= r_acc + mdu_res;
                        hpe_pkg::STP_V2:  r_acc <= r_acc + mdu_res;
                        hpe_pkg::STP_V3:  r_rs_val <= hpe_pkg::sat32(r_acc + mdu_res);
                        hpe_pkg::STP_S:   r_s   <= hpe_pkg::Q_W'(mdu_res);
                        hpe_pkg::STP_R0:  r_acc <= six_r;
                        hpe_pkg::STP_R1:  r_acc <= r_acc + mdu_res;
                        hpe_pkg::STP_R2:  r_rs_rate <= hpe_pkg::sat32(r_acc + mdu_res);
                        hpe_pkg::STP_S2:  r_s2  <= hpe_pkg::Q_W'(mdu_res);
                        hpe_pkg::STP_P0:  r_p0  <= hpe_pkg::Q_W'(mdu_res);
                        hpe_pkg::STP_P1:  r_p1  <= hpe_pkg::Q_W'(mdu_res);
                        hpe_pkg::STP_B0:  r_acc <= six_r;
                        hpe_pkg::STP_B1:  r_acc <= r_acc + six_r - (64'(r_p0) <<< 2);
                        hpe_pkg::STP_B2: begin
                            r_rs_bend <= hpe_pkg::sat32(r_acc + six_r - (64'(r_p1) <<< 1));
                        end
                        default: begin
                        end
                    endcase
                end
            end
            hpe_pkg::S_OUT: begin
                if (out_free) begin
                    r_out_status <= r_rs_status;
                    r_out_data   <= {r_rs_bend, r_rs_rate, r_rs_val};
                end
            end
            default: begin
            end
        endcase
    end

    hpe_mdu u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mdu_req),
        .o_done   (mdu_done),
        .o_result (mdu_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule
